/* rtl/tlbr_pkg.sv */
`timescale 1ns / 1ps

package tlbr_pkg;

  localparam int TLB_SIZE_DEF  = 4;
  localparam int PAGE_SIZE_DEF = 128;

  localparam int ADDR_W  = 32;
  localparam int VPAGE_W = 25;
  localparam int PPAGE_W = 10;
  localparam int FLAG_W  = 3;
  localparam int AGE_W   = 16;
  localparam int LFSR_W  = 16;
  localparam int SLOT_W  = 2;
  localparam int POL_W   = 2;

  localparam logic [AGE_W-1:0]  AGE_MAX    = '1;
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;

  // replacement policy codes
  localparam logic [POL_W-1:0] POL_FIFO   = 2'd0;
  localparam logic [POL_W-1:0] POL_AGE    = 2'd1;
  localparam logic [POL_W-1:0] POL_RAND   = 2'd2;
  localparam logic [POL_W-1:0] POL_UNUSED = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [VPAGE_W-1:0] vpage;
    logic [PPAGE_W-1:0] ppage;
    logic [FLAG_W-1:0]  flags;   // bit0 read-only, bit1 used, bit2 dirty
  } entry_t;

  // commit command broadcast to every cell
  typedef struct packed {
    logic write;    // load new entry into selected cell
    logic shift;    // FIFO: every cell takes its upper neighbour
    logic bump;     // saturating age increment
    logic clr_age;  // clear age of selected cell
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // unused code behaves as largest-age
  function automatic logic [POL_W-1:0] eff_policy(input logic [POL_W-1:0] p);
    return (p == POL_UNUSED) ? POL_AGE : p;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

/* rtl/tlbr_cell.sv */
`timescale 1ns / 1ps

// One TLB entry plus its age; also one stage of the victim search chain.
module tlbr_cell #(
  parameter int TLB_SIZE = 4,
  parameter int IDX      = 0,
  localparam int IdxW    = $clog2(TLB_SIZE)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tlbr_pkg::cmd_t            cmd,
  input  logic [IdxW-1:0]           sel_idx,
  input  tlbr_pkg::entry_t          new_ent,
  input  tlbr_pkg::entry_t          nbr_ent,
  output tlbr_pkg::entry_t          ent_o,
  input  logic                      free_i,
  input  logic [IdxW-1:0]           free_idx_i,
  input  logic [IdxW-1:0]           max_idx_i,
  input  logic [tlbr_pkg::AGE_W-1:0] max_age_i,
  output logic                      free_o,
  output logic [IdxW-1:0]           free_idx_o,
  output logic [IdxW-1:0]           max_idx_o,
  output logic [tlbr_pkg::AGE_W-1:0] max_age_o
);
  import tlbr_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  entry_t           ent_r, ent_nxt;
  logic [AGE_W-1:0] age_r, age_nxt, age_inc;
  logic             mine, take;

  assign mine    = (sel_idx == MyIdx);
  assign age_inc = (age_r == AGE_MAX) ? age_r : age_r + 1'b1;
  // strict compare: ties stay with the lower index further up the chain
  assign take    = (age_inc > max_age_i);

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.shift) begin
      ent_nxt = nbr_ent;
    end else if (cmd.write && mine) begin
      ent_nxt = new_ent;
    end
    age_nxt = age_r;
    if (cmd.clr_age && mine) begin
      age_nxt = '0;
    end else if (cmd.bump) begin
      age_nxt = age_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      age_r <= '0;
    end else begin
      ent_r <= ent_nxt;
      age_r <= age_nxt;
    end
  end

  // search record, free running
  always_ff @(posedge clk) begin
    free_o     <= free_i | ~ent_r.valid;
    free_idx_o <= free_i ? free_idx_i : MyIdx;
    max_idx_o  <= take ? MyIdx : max_idx_i;
    max_age_o  <= take ? age_inc : max_age_i;
  end

  assign ent_o = ent_r;

endmodule

/* rtl/tlbr_rand.sv */
`timescale 1ns / 1ps

// LFSR, and the remainder of its next value by TLB_SIZE through a reciprocal
// multiply: start loads work_r, then quot_r and then rem_r are registered.
module tlbr_rand #(
  parameter int TLB_SIZE = 4,
  localparam int IdxW    = $clog2(TLB_SIZE)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            step,
  output logic            done,
  output logic [IdxW-1:0] rnd_idx
);
  import tlbr_pkg::*;

  localparam int ProdW = LFSR_W + 32;
  // floor(2^32 / TLB_SIZE) + 1: the quotient is exact for every 16-bit value
  localparam logic [31:0]       Recip   = 32'((64'd1 << 32) / TLB_SIZE + 1);
  localparam logic [LFSR_W-1:0] Divisor = LFSR_W'(TLB_SIZE);

  logic [LFSR_W-1:0] lfsr_r, work_r, quot_r, rem_full;
  logic [ProdW-1:0]  prod;
  logic [IdxW-1:0]   rem_r;
  logic              q_pend_r, r_pend_r;

  assign prod     = {32'd0, work_r} * {{LFSR_W{1'b0}}, Recip};
  assign rem_full = work_r - quot_r * Divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r   <= LFSR_SEED;
      q_pend_r <= 1'b0;
      r_pend_r <= 1'b0;
    end else begin
      if (step) begin
        lfsr_r <= lfsr_next(lfsr_r);
      end
      q_pend_r <= start;
      r_pend_r <= q_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= lfsr_next(lfsr_r);
    end
    if (q_pend_r) begin
      quot_r <= prod[ProdW-1:32];
    end
    if (r_pend_r) begin
      rem_r <= rem_full[IdxW-1:0];
    end
  end

  assign done    = ~(q_pend_r | r_pend_r);
  assign rnd_idx = rem_r;

endmodule

/* rtl/tlb_refill_replacement.sv */
`timescale 1ns / 1ps

// TLB refill with selectable victim choice.
// in_ channel: one transaction per TLB miss - faulting address and the fetched
//   page-table entry. in_tuser carries the entry's valid bit; when it is low
//   the result flags a page fault and nothing in the TLB changes.
// out_ channel: one transaction per miss - slot written, eviction flag and the
//   displaced virtual page; out_tuser is the page-fault flag.
// cfg_ port: policy register (0 FIFO shift, 1 largest age, 2 LFSR random,
//   3 as 1), reset value 1. Write it only while no miss is in flight.
// Each entry sits in a cell of a chain; a search record (first free slot,
// oldest slot) ripples one cell per cycle, so a miss is accepted, scanned as
// the record runs the length of the chain, and committed. Under the random
// policy the commit also waits for the remainder of the LFSR by TLB_SIZE
// (reciprocal multiply). One miss at a time.
// The result sits in an output register; the next miss is taken while it
// waits, but its commit holds until out_tready frees that register.
// Reset (rst_n low, synchronous) empties the TLB, zeroes the ages, loads the
// LFSR with 0xACE1 and selects policy 1. PAGE_SIZE must be a power of two.
module tlb_refill_replacement
  import tlbr_pkg::*;
#(
  parameter int TLB_SIZE  = TLB_SIZE_DEF,
  parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bad_address[31:0], refill_physical_page[41:32], refill_read_only[42],
  // refill_used[43], refill_dirty[44], zero pad[47:45]
  input  logic [47:0] in_tdata,
  // refill_valid[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[1:0], evicted[2], evicted_virtual_page[27:3], zero pad[31:28]
  output logic [31:0] out_tdata,
  // page_fault[0]
  output logic        out_tuser
);

  localparam int IdxW      = $clog2(TLB_SIZE);
  localparam int PageShift = $clog2(PAGE_SIZE);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TLB_SIZE - 1);

  // control
  state_t          state_r, state_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;
  logic [POL_W-1:0] pol_r, pol;
  logic            acc, commit, scan_done, out_free;

  // captured miss
  logic [ADDR_W-1:0]  addr_r;
  logic               rvalid_r;
  logic [PPAGE_W-1:0] ppage_r;
  logic [FLAG_W-1:0]  flags_r;
  logic [ADDR_W-1:0]  addr_sh;
  entry_t             new_ent;

  // result register
  logic               out_tvalid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_fault_r, out_ev_r;
  logic [VPAGE_W-1:0] out_vpage_r;

  // chain
  entry_t           ent_q [TLB_SIZE];
  logic             rec_free [TLB_SIZE];
  logic [IdxW-1:0]  rec_free_idx [TLB_SIZE];
  logic [IdxW-1:0]  rec_max_idx [TLB_SIZE];
  logic [AGE_W-1:0] rec_max_age [TLB_SIZE];
  cmd_t             cmd;
  logic [IdxW-1:0]  chosen, ev_idx, rnd_idx;
  logic             evict, rnd_done, rnd_step;

  assign pol       = eff_policy(pol_r);
  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid_r | out_tready;
  assign scan_done = (cnt_r == LastIdx) && ((pol != POL_RAND) || rnd_done);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r != LastIdx) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (scan_done && out_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pol_r   <= POL_AGE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        pol_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      addr_r   <= in_tdata[31:0];
      rvalid_r <= in_tuser;
      ppage_r  <= in_tdata[41:32];
      flags_r  <= in_tdata[44:42];
    end
  end

  assign addr_sh = addr_r >> PageShift;
  assign new_ent = '{valid: 1'b1, vpage: addr_sh[VPAGE_W-1:0], ppage: ppage_r,
                     flags: flags_r};

  // victim choice from the record leaving the last cell
  assign evict = ~rec_free[TLB_SIZE-1];

  always_comb begin
    priority if (!evict) begin
      chosen = rec_free_idx[TLB_SIZE-1];
    end else if (pol == POL_FIFO) begin
      chosen = LastIdx;
    end else if (pol == POL_RAND) begin
      chosen = rnd_idx;
    end else begin
      chosen = rec_max_idx[TLB_SIZE-1];
    end
  end

  // FIFO displaces slot 0 before the shift
  assign ev_idx = (pol == POL_FIFO) ? '0 : chosen;

  assign cmd.write   = commit & rvalid_r;
  assign cmd.shift   = cmd.write & evict & (pol == POL_FIFO);
  assign cmd.bump    = cmd.write & (pol != POL_FIFO);
  assign cmd.clr_age = cmd.write & (pol == POL_AGE);
  assign rnd_step    = cmd.write & evict & (pol == POL_RAND);

  genvar gi;
  generate
    for (gi = 0; gi < TLB_SIZE; gi++) begin : g_cell
      entry_t           nbr;
      logic             free_in;
      logic [IdxW-1:0]  free_idx_in, max_idx_in;
      logic [AGE_W-1:0] max_age_in;

      if (gi == TLB_SIZE - 1) begin : g_top
        assign nbr = new_ent;
      end else begin : g_mid
        assign nbr = ent_q[gi+1];
      end

      if (gi == 0) begin : g_head
        assign free_in     = 1'b0;
        assign free_idx_in = '0;
        assign max_idx_in  = '0;
        assign max_age_in  = '0;
      end else begin : g_link
        assign free_in     = rec_free[gi-1];
        assign free_idx_in = rec_free_idx[gi-1];
        assign max_idx_in  = rec_max_idx[gi-1];
        assign max_age_in  = rec_max_age[gi-1];
      end

      tlbr_cell #(
        .TLB_SIZE (TLB_SIZE),
        .IDX      (gi)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sel_idx    (chosen),
        .new_ent    (new_ent),
        .nbr_ent    (nbr),
        .ent_o      (ent_q[gi]),
        .free_i     (free_in),
        .free_idx_i (free_idx_in),
        .max_idx_i  (max_idx_in),
        .max_age_i  (max_age_in),
        .free_o     (rec_free[gi]),
        .free_idx_o (rec_free_idx[gi]),
        .max_idx_o  (rec_max_idx[gi]),
        .max_age_o  (rec_max_age[gi])
      );
    end
  endgenerate

  tlbr_rand #(
    .TLB_SIZE (TLB_SIZE)
  ) u_rand (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (acc),
    .step    (rnd_step),
    .done    (rnd_done),
    .rnd_idx (rnd_idx)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_fault_r <= ~rvalid_r;
      out_slot_r  <= rvalid_r ? SLOT_W'(chosen) : '0;
      out_ev_r    <= rvalid_r & evict;
      out_vpage_r <= (rvalid_r && evict) ? ent_q[ev_idx].vpage : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_vpage_r, out_ev_r, out_slot_r};
  assign out_tuser  = out_fault_r;

  // a new result only appears at the end of a scan
  a_rise_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_SCAN))
    else $error("result raised without a finished scan");

  // page faults never report a slot or an eviction
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[27:0] == 28'd0))
    else $error("page fault result carries slot or eviction");

  // the slot written by a commit holds a valid entry afterwards
  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> ent_q[$past(chosen)].valid)
    else $error("written slot not valid");

  // an eviction is only reported while the first and last slots hold valid entries
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && rvalid_r && evict) |-> ent_q[0].valid && ent_q[TLB_SIZE-1].valid)
    else $error("eviction while a slot was free");

endmodule
